// ===== rtl/rps_pkg.sv =====
// Shared types and constants for the reversible pixel shuffle.
// Used by rps_half and reversible_pixel_shuffle.
package rps_pkg;

    localparam int             COORD_W   = 14;
    localparam int             DIM_W     = 15;
    localparam int             SEED_W    = 32;
    localparam logic [DIM_W-1:0] MAX_DIM = 15'd16384;
    localparam logic [31:0]    HASH_XOR  = 32'd61;
    localparam logic [31:0]    HASH_MUL  = 32'h27d4eb2d;
    localparam int             HALVES    = 4;
    localparam int             DIV_STG   = 8;
    localparam int             DIV_BITS  = 4;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_REVERSE = 1'b1;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        ph;
        logic              inb;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SEED_W-1:0] seed;
    } t_item;

endpackage

// ===== rtl/rps_half.sv =====
// One half round: Wang hash of one coordinate, pipelined remainder, fold.
// Depends on rps_pkg.
module rps_half import rps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DIM_W-1:0]   i_w,
    input  logic [DIM_W-1:0]   i_h,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output t_item              o_item
);

    localparam int NST = DIV_STG + 4;
    localparam int FST = NST - 1;

    logic              r_vld [NST];
    t_item             r_it  [NST];
    logic [31:0]       r_acc [DIV_STG+2];
    logic [DIM_W-1:0]  r_rem [DIV_STG];
    logic              r_neg [DIV_STG+1];
    logic              en    [NST];

    logic [DIM_W-1:0]  n_rem [DIV_STG];
    logic [31:0]       n_a3;
    logic [31:0]       n_a4;
    logic [31:0]       n_mag;
    logic              n_neg;
    t_item             n_fold;

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic upd_x(input t_item it);
        upd_x = !(it.cmd ^ it.ph[0]);
    endfunction

    function automatic logic [DIM_W-1:0] sel_n(input t_item it, input logic [DIM_W-1:0] w,
                                               input logic [DIM_W-1:0] h);
        sel_n = upd_x(it) ? w : h;
    endfunction

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NST-1];
    assign o_item  = r_it[NST-1];

    // hash front end
    always_comb begin
        logic [31:0] k;
        logic [31:0] a1;
        logic [31:0] a2;
        k    = {{(32-COORD_W){1'b0}}, (upd_x(i_item) ? i_item.y : i_item.x)} ^ i_item.seed;
        a1   = k ^ HASH_XOR ^ asr(k, 16);
        a2   = a1 + (a1 << 3);
        n_a3 = a2 ^ asr(a2, 4);
    end

    assign n_a4 = r_acc[0] * HASH_MUL;

    always_comb begin
        logic [31:0] a5;
        a5    = r_acc[1] ^ asr(r_acc[1], 15);
        n_neg = a5[31];
        n_mag = a5[31] ? (~a5 + 32'd1) : a5;
    end

    // restoring remainder, DIV_BITS bits per stage
    always_comb begin
        for (int d = 0; d < DIV_STG; d++) begin
            logic [DIM_W-1:0] t;
            logic [DIM_W-1:0] n;
            logic [31:0]      m;
            t = (d == 0) ? '0 : r_rem[(d == 0) ? 0 : d-1];
            n = sel_n(r_it[d+2], i_w, i_h);
            m = r_acc[d+2];
            for (int b = 0; b < DIV_BITS; b++) begin
                t = {t[DIM_W-2:0], m[31-b]};
                if (t >= n) begin
                    t = t - n;
                end
            end
            n_rem[d] = t;
        end
    end

    // sign and fold back into [0, n)
    always_comb begin
        logic signed [16:0] rs;
        logic signed [16:0] c;
        logic signed [16:0] v;
        logic signed [16:0] n;
        logic              ux;
        t_item             it;
        it = r_it[FST-1];
        ux = upd_x(it);
        n  = $signed({2'b00, sel_n(it, i_w, i_h)});
        rs = $signed({2'b00, r_rem[DIV_STG-1]});
        if (r_neg[DIV_STG]) begin
            rs = -rs;
        end
        c = $signed({3'b000, (ux ? it.x : it.y)});
        v = (it.cmd == CMD_REVERSE) ? (c - rs) : (c + rs);
        if (v < 0) begin
            v = v + n;
        end else if (v >= n) begin
            v = v - n;
        end
        n_fold = it;
        if (ux) begin
            n_fold.x = v[COORD_W-1:0];
        end else begin
            n_fold.y = v[COORD_W-1:0];
        end
        n_fold.ph = it.ph + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_it[0]  <= i_item;
            r_acc[0] <= n_a3;
        end
        if (en[1]) begin
            r_it[1]  <= r_it[0];
            r_acc[1] <= n_a4;
        end
        if (en[2]) begin
            r_it[2]  <= r_it[1];
            r_acc[2] <= n_mag;
            r_neg[0] <= n_neg;
        end
        for (int d = 0; d < DIV_STG; d++) begin
            if (en[d+3]) begin
                r_it[d+3]  <= r_it[d+2];
                r_rem[d]   <= n_rem[d];
                r_neg[d+1] <= r_neg[d];
                if (d < DIV_STG - 1) begin
                    r_acc[d+3] <= r_acc[d+2] << DIV_BITS;
                end
            end
        end
        if (en[FST]) begin
            r_it[FST] <= n_fold;
        end
    end

endmodule

// ===== rtl/reversible_pixel_shuffle.sv =====
// Reversible pixel shuffle: seeded two-round Feistel permutation of a grid.
// Four half rounds of 12 stages each: hash, multiply, sign, eight remainder
// stages of 4 bits, fold. Throughput one transfer per cycle unless m_axis stalls.
// Synchronous active-low reset clears valids; grid width and height reset to 1024.
// Depends on rps_pkg and rps_half.
module reversible_pixel_shuffle import rps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [63:0]       i_s_axis_tdata,   // x_in, y_in, seed
    input  logic              i_s_axis_tuser,   // command
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // x_out, y_out
    output logic              o_m_axis_tuser    // in_bounds
);

    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    logic  vld [HALVES+1];
    logic  rdy [HALVES+1];
    t_item itm [HALVES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 15'd1024;
            r_grid_height <= 15'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (r_grid_width  > MAX_DIM) ? MAX_DIM : r_grid_width;
    assign h_eff = (r_grid_height > MAX_DIM) ? MAX_DIM : r_grid_height;

    always_comb begin
        itm[0].cmd  = i_s_axis_tuser;
        itm[0].ph   = 2'd0;
        itm[0].x    = i_s_axis_tdata[13:0];
        itm[0].y    = i_s_axis_tdata[27:14];
        itm[0].seed = i_s_axis_tdata[59:28];
        itm[0].inb  = (w_eff != '0) && (h_eff != '0)
                   && ({1'b0, i_s_axis_tdata[13:0]} < w_eff)
                   && ({1'b0, i_s_axis_tdata[27:14]} < h_eff);
    end

    assign vld[0]          = i_s_axis_tvalid;
    assign o_s_axis_tready = rdy[0];

    for (genvar g = 0; g < HALVES; g++) begin : g_half
        rps_half u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_w     (w_eff),
            .i_h     (h_eff),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_item  (itm[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_item  (itm[g+1])
        );
    end

    assign rdy[HALVES]     = i_m_axis_tready;
    assign o_m_axis_tvalid = vld[HALVES];
    assign o_m_axis_tuser  = itm[HALVES].inb;
    assign o_m_axis_tdata  = {4'b0000,
                              itm[HALVES].inb ? itm[HALVES].y : {COORD_W{1'b0}},
                              itm[HALVES].inb ? itm[HALVES].x : {COORD_W{1'b0}}};

`ifndef SYNTHESIS
    a_out_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (({1'b0, o_m_axis_tdata[13:0]} < w_eff) && ({1'b0, o_m_axis_tdata[27:14]} < h_eff)))
        else $error("mapped coordinate outside grid");
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");
`endif

endmodule
